[sv/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared sizes, request codes and status codes of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths on the ports
  localparam int REQ_W        = 3;
  localparam int VALUE_W      = 32;
  localparam int OFFSET_W     = 4;
  localparam int READ_DATA_W  = 32;
  localparam int STATUS_W     = 2;
  localparam int ITEM_COUNT_W = 5;

  // Packed word widths, padded to whole bytes
  localparam int IN_FIELDS_W  = VALUE_W + OFFSET_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = READ_DATA_W + STATUS_W + ITEM_COUNT_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Width used for head plus offset and for the offset range check
  localparam int SUM_W = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_PEEK_FRONT = 3'd3,
    REQ_READ_AT    = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

[sv/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/circular_deque_top.sv]
// ----------------------------------------------------------------------------
// circular_deque_top
// Ring-buffer deque: push back, push front, pop front, peek front and read at
// an offset from the head, with one result word per request.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the in_ stream: the request kind in in_tuser, the push
//   word and the read offset in in_tdata. Each accepted word yields exactly
//   one result word on the out_ stream carrying the data read, a status, the
//   entry count after the request and the empty and full flags.
//   Pushes and requests that read nothing (rejected or failed) are answered
//   from the output register in the cycle after acceptance. Pop, peek and read
//   at offset go through the single read port of the slot RAM, whose read data
//   is registered and then passed into the output register; no new request is
//   taken meanwhile. One request is in flight at a time.
//   Reset (rst_n low, synchronous) empties the deque: head, tail and count go
//   to zero; the slot RAM is not cleared, as only written slots are ever read.
//   A result waiting on a stalled receiver is held in the output register; a
//   new request is taken in the same cycle that result is taken.
// ----------------------------------------------------------------------------
module circular_deque_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: push_value [31:0], offset [35:32], zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type [2:0]
  input  logic [cdq_pkg::REQ_W-1:0]       in_tuser,
  // out_tdata: read_data [31:0], status [33:32], item_count [38:34],
  //            is_empty [39], is_full [40], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cdq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = cdq_pkg::IDX_W;
  localparam int CNT_W = cdq_pkg::CNT_W;
  localparam int SUM_W = cdq_pkg::SUM_W;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                                out_tvalid_r;
  logic [cdq_pkg::READ_DATA_W-1:0]     out_data_r;
  cdq_pkg::status_t                    out_status_r;
  logic [cdq_pkg::ITEM_COUNT_W-1:0]    out_count_r;
  logic                                out_empty_r;
  logic                                out_full_r;

  logic                               accept;
  cdq_pkg::req_t                      req;
  logic [cdq_pkg::DATA_WIDTH-1:0]     push_word;
  logic [cdq_pkg::OFFSET_W-1:0]       offset;
  logic                               is_empty;
  logic                               is_full;
  cdq_pkg::status_t                   status;
  logic [SUM_W-1:0]                   off_sum;
  logic [SUM_W-1:0]                   at_sum;
  logic [IDX_W-1:0]                   at_addr;

  logic                               ram_we;
  logic [IDX_W-1:0]                   ram_waddr;
  logic                               ram_re;
  logic [IDX_W-1:0]                   ram_raddr;
  logic [cdq_pkg::DATA_WIDTH-1:0]     ram_rdata;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(cdq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(cdq_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign req       = cdq_pkg::req_t'(in_tuser);
  assign push_word = cdq_pkg::DATA_WIDTH'(in_tdata[cdq_pkg::VALUE_W-1:0]);
  assign offset    = in_tdata[cdq_pkg::VALUE_W +: cdq_pkg::OFFSET_W];
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CNT_W'(cdq_pkg::DEPTH));

  // Head plus offset stays below twice the depth when the offset is in range
  assign off_sum = SUM_W'(head_r) + SUM_W'(offset);
  assign at_sum  = (off_sum >= SUM_W'(cdq_pkg::DEPTH)) ?
                   off_sum - SUM_W'(cdq_pkg::DEPTH) : off_sum;
  assign at_addr = at_sum[IDX_W-1:0];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    status    = cdq_pkg::ST_OK;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_re    = 1'b0;
    ram_raddr = head_r;
    if (accept) begin
      case (req)
        cdq_pkg::REQ_PUSH_BACK: begin
          if (is_full) begin
            status = cdq_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            tail_nxt  = idx_next(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        cdq_pkg::REQ_PUSH_FRONT: begin
          if (is_full) begin
            status = cdq_pkg::ST_FULL;
          end else if (is_empty) begin
            ram_we    = 1'b1;
            tail_nxt  = idx_next(tail_r);
            count_nxt = count_r + 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = idx_prev(head_r);
            head_nxt  = idx_prev(head_r);
            count_nxt = count_r + 1'b1;
          end
        end
        cdq_pkg::REQ_POP_FRONT: begin
          if (is_empty) begin
            status = cdq_pkg::ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            head_nxt  = idx_next(head_r);
            count_nxt = count_r - 1'b1;
          end
        end
        cdq_pkg::REQ_PEEK_FRONT: begin
          if (is_empty) begin
            status = cdq_pkg::ST_EMPTY;
          end else begin
            ram_re = 1'b1;
          end
        end
        cdq_pkg::REQ_READ_AT: begin
          if (is_empty) begin
            status = cdq_pkg::ST_EMPTY;
          end else if (SUM_W'(offset) >= SUM_W'(count_r)) begin
            status = cdq_pkg::ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = at_addr;
          end
        end
        default: begin
          status = cdq_pkg::ST_OK;
        end
      endcase
    end
  end

  cdq_ram #(
    .DEPTH  (cdq_pkg::DEPTH),
    .WIDTH  (cdq_pkg::DATA_WIDTH),
    .ADDR_W (IDX_W)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_status_r <= status;
            out_count_r  <= cdq_pkg::ITEM_COUNT_W'(count_nxt);
            out_empty_r  <= (count_nxt == '0);
            out_full_r   <= (count_nxt == CNT_W'(cdq_pkg::DEPTH));
            if (ram_re) begin
              // hold the result back until the slot word arrives
              out_tvalid_r <= 1'b0;
              state_r      <= S_READ;
            end else begin
              out_data_r   <= '0;
              out_tvalid_r <= 1'b1;
            end
          end else if (out_tready) begin
            out_tvalid_r <= 1'b0;
          end
        end
        S_READ: begin
          out_data_r   <= cdq_pkg::READ_DATA_W'(ram_rdata);
          out_tvalid_r <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = cdq_pkg::OUT_TDATA_W'({out_full_r, out_empty_r, out_count_r,
                                             out_status_r, out_data_r});

  // Count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(cdq_pkg::DEPTH))
    else $error("entry count above capacity");

  // Head and tail coincide when the deque is empty or full
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '0) || (count_r == CNT_W'(cdq_pkg::DEPTH))) |-> (head_r == tail_r))
    else $error("head and tail disagree with an empty or full count");

  // While a slot read is outstanding the output register is free
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_tvalid_r)
    else $error("result register busy during slot read");

  // A read request issued to the RAM moves to S_READ and then delivers its result
  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (state_r == S_READ) ##1 out_tvalid_r)
    else $error("slot read did not produce a result");

  // No RAM read and write in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_re && ram_we))
    else $error("slot read and write overlap");

endmodule
